// ----- rtl/core/kqt_pkg.sv -----
// Package: shared types and codes for the keyed quantity table.
`default_nettype none
package kqt_pkg;
    localparam int KQT_CAPACITY = 32;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_SEARCH = 2'd1,
        OP_UPDATE = 2'd2,
        OP_DUMP   = 2'd3
    } t_op;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_EXISTS    = 3'd1;
    localparam logic [2:0] ST_NOT_FOUND = 3'd2;
    localparam logic [2:0] ST_FULL      = 3'd3;
    localparam logic [2:0] ST_EMPTY     = 3'd4;

    typedef struct packed {
        logic signed [31:0] key;
        logic signed [31:0] qty;
    } t_entry;

    // command broadcast to every cell
    typedef struct packed {
        logic   shift_ins;
        logic   rotate;
        logic   wr_qty;
        t_entry data;
    } t_cell_cmd;
endpackage
`default_nettype wire

// ----- rtl/core/kqt_ifs.sv -----
// Interfaces: command word and response word channels.
`default_nettype none
interface kqt_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         opcode;
    logic signed [31:0] part_key;
    logic signed [31:0] amount;
    modport source(output valid, opcode, part_key, amount, input ready);
    modport sink(input valid, opcode, part_key, amount, output ready);
endinterface

interface kqt_out_if;
    logic               valid;
    logic               ready;
    logic [2:0]         status;
    logic signed [31:0] result_key;
    logic signed [31:0] result_quantity;
    logic               last;
    modport source(output valid, status, result_key, result_quantity, last, input ready);
    modport sink(input valid, status, result_key, result_quantity, last, output ready);
endinterface
`default_nettype wire

// ----- rtl/core/kqt_cell.sv -----
// Cell: one table entry, sorted insert shift, dump rotation and quantity write.
`default_nettype none
module kqt_cell
    import kqt_pkg::*;
(
    input  wire logic      i_clk,
    input  wire t_cell_cmd i_cmd,
    input  wire logic      i_valid,
    input  wire logic      i_at_end,
    input  wire logic      i_prev_gt,
    input  wire logic      i_sel,
    input  wire t_entry    i_left,
    input  wire t_entry    i_right,
    output t_entry         o_entry,
    output logic           o_gt,
    output logic           o_hit
);
    t_entry r_entry;
    logic   take;

    assign o_gt    = i_valid && (r_entry.key > i_cmd.data.key);
    assign o_hit   = i_valid && (r_entry.key == i_cmd.data.key);
    assign take    = o_gt || i_at_end;
    assign o_entry = r_entry;

    always_ff @(posedge i_clk) begin
        if (i_cmd.rotate) begin
            r_entry <= i_right;
        end else if (i_cmd.shift_ins && take) begin
            r_entry <= i_prev_gt ? i_left : i_cmd.data;
        end else if (i_cmd.wr_qty && i_sel) begin
            r_entry.qty <= i_cmd.data.qty;
        end
    end
endmodule
`default_nettype wire

// ----- rtl/core/keyed_quantity_table.sv -----
// Keyed quantity table: up to CAPACITY unique signed keys with quantities.
// Command words (i_cmd): insert, search, update (saturating add), sorted dump.
// Response words (o_rsp): status, key, quantity, last; last marks the final
// word of each command. The entries sit in a row of cells kept in ascending
// key order: an insert shifts all larger keys one cell right together.
// Insert and search load the response register from the execute state;
// update looks up there, then loads cell and response via one saturating adder.
// A new command is taken only once the previous one is finished. A dump
// rotates the cell row once around its CAPACITY cells, one cell per cycle
// unless a stalled receiver holds a pending entry word, emitting cell 0
// while it holds a stored entry; an empty table gives one EMPTY word.
// A stalled receiver holds the response register; a command with a word to
// emit then waits with the row frozen and resumes when the word is taken.
// The input stays ready while a finished response waits. Reset empties the
// table (entry count 0); the cells themselves are not cleared.
`default_nettype none
module keyed_quantity_table
    import kqt_pkg::*;
#(
    parameter int CAPACITY = KQT_CAPACITY
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    kqt_in_if.sink     i_cmd,
    kqt_out_if.source  o_rsp
);
    localparam int CNTW = $clog2(CAPACITY + 1);
    localparam int SW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

    typedef enum logic [1:0] {S_IDLE, S_EXEC, S_UPD, S_DUMP} t_state;

    t_state             r_state, n_state;
    logic [CNTW-1:0]    r_count, n_count;
    logic [SW-1:0]      r_step, n_step;
    t_op                r_op, n_op;
    logic signed [31:0] r_key, n_key, r_amt, n_amt, r_mq, n_mq;
    logic               r_o_valid, n_o_valid, r_o_last, n_o_last;
    logic [2:0]         r_o_status, n_o_status;
    logic signed [31:0] r_o_key, n_o_key, r_o_qty, n_o_qty;

    t_cell_cmd          cmd;
    t_entry             ent [CAPACITY];
    logic [CAPACITY-1:0] gt, hit;
    t_entry             match;
    logic               any_hit, can_emit, in_dump, dump_emit;
    logic [32:0]        sum;
    logic signed [31:0] sat;

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
            kqt_cell u_cell (
                .i_clk     (i_clk),
                .i_cmd     (cmd),
                .i_valid   (CNTW'(gi) < r_count),
                .i_at_end  (CNTW'(gi) == r_count),
                .i_prev_gt ((gi > 0) ? gt[(gi > 0) ? gi - 1 : 0] : 1'b0),
                .i_sel     (hit[gi]),
                .i_left    (ent[(gi > 0) ? gi - 1 : 0]),
                .i_right   (ent[(gi + 1) % CAPACITY]),
                .o_entry   (ent[gi]),
                .o_gt      (gt[gi]),
                .o_hit     (hit[gi])
            );
        end
    endgenerate

    always_comb begin
        match = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            match = match | (hit[i] ? ent[i] : '0);
        end
    end

    assign any_hit   = |hit;
    assign can_emit  = !r_o_valid || o_rsp.ready;
    assign in_dump   = (r_state == S_DUMP);
    assign dump_emit = CNTW'(r_step) < r_count;
    assign sum       = {r_mq[31], r_mq} + {r_amt[31], r_amt};
    assign sat       = (sum[32] != sum[31]) ? (sum[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF)
                                            : $signed(sum[31:0]);

    assign i_cmd.ready           = (r_state == S_IDLE);
    assign o_rsp.valid           = r_o_valid;
    assign o_rsp.status          = r_o_status;
    assign o_rsp.result_key      = r_o_key;
    assign o_rsp.result_quantity = r_o_qty;
    assign o_rsp.last            = r_o_last;

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_step     = r_step;
        n_op       = r_op;
        n_key      = r_key;
        n_amt      = r_amt;
        n_mq       = r_mq;
        n_o_valid  = r_o_valid && !o_rsp.ready;
        n_o_status = r_o_status;
        n_o_key    = r_o_key;
        n_o_qty    = r_o_qty;
        n_o_last   = r_o_last;
        cmd           = '0;
        cmd.data.key  = r_key;
        cmd.data.qty  = r_amt;

        unique case (r_state)
            S_IDLE: begin
                if (i_cmd.valid) begin
                    n_op    = t_op'(i_cmd.opcode);
                    n_key   = i_cmd.part_key;
                    n_amt   = i_cmd.amount;
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (can_emit) begin
                    n_state    = S_IDLE;
                    n_o_valid  = 1'b1;
                    n_o_last   = 1'b1;
                    n_o_status = ST_OK;
                    n_o_key    = '0;
                    n_o_qty    = '0;
                    unique case (r_op)
                        OP_INSERT: begin
                            if (r_count == CNTW'(CAPACITY)) begin
                                n_o_status = ST_FULL;
                            end else if (any_hit) begin
                                n_o_status = ST_EXISTS;
                                n_o_key    = match.key;
                                n_o_qty    = match.qty;
                            end else begin
                                cmd.shift_ins = 1'b1;
                                n_count       = r_count + CNTW'(1);
                                n_o_key       = r_key;
                                n_o_qty       = r_amt;
                            end
                        end
                        OP_SEARCH: begin
                            if (any_hit) begin
                                n_o_key = match.key;
                                n_o_qty = match.qty;
                            end else begin
                                n_o_status = ST_NOT_FOUND;
                            end
                        end
                        OP_UPDATE: begin
                            if (any_hit) begin
                                n_o_valid = 1'b0;
                                n_mq      = match.qty;
                                n_state   = S_UPD;
                            end else begin
                                n_o_status = ST_NOT_FOUND;
                            end
                        end
                        OP_DUMP: begin
                            if (r_count == '0) begin
                                n_o_status = ST_EMPTY;
                            end else begin
                                n_o_valid = 1'b0;
                                n_step    = '0;
                                n_state   = S_DUMP;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_UPD: begin
                if (can_emit) begin
                    cmd.wr_qty   = 1'b1;
                    cmd.data.qty = sat;
                    n_o_valid    = 1'b1;
                    n_o_last     = 1'b1;
                    n_o_status   = ST_OK;
                    n_o_key      = r_key;
                    n_o_qty      = sat;
                    n_state      = S_IDLE;
                end
            end
            S_DUMP: begin
                if (can_emit || !dump_emit) begin
                    cmd.rotate = 1'b1;
                    n_step     = r_step + SW'(1);
                    if (dump_emit) begin
                        n_o_valid  = 1'b1;
                        n_o_status = ST_OK;
                        n_o_key    = ent[0].key;
                        n_o_qty    = ent[0].qty;
                        n_o_last   = (CNTW'(r_step) == r_count - CNTW'(1));
                    end
                    if (r_step == SW'(CAPACITY - 1)) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_o_valid <= n_o_valid;
        end
        r_step     <= n_step;
        r_op       <= n_op;
        r_key      <= n_key;
        r_amt      <= n_amt;
        r_mq       <= n_mq;
        r_o_status <= n_o_status;
        r_o_key    <= n_o_key;
        r_o_qty    <= n_o_qty;
        r_o_last   <= n_o_last;
    end

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNTW'(CAPACITY))
        else $error("entry count above capacity");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.valid && i_cmd.ready |=> !i_cmd.ready)
        else $error("command taken while previous one still executes");

    a_empty_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid && (r_o_status == ST_EMPTY) |-> r_o_last && (r_count == '0))
        else $error("empty response without last or with entries stored");

    a_dump_frozen: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_dump |=> r_count == $past(r_count))
        else $error("entry count changed during dump");
endmodule
`default_nettype wire
